[hdl/fshh_pkg.sv]
package fshh_pkg;

   // sizes of the stores
   localparam int Flows        = 256;
   localparam int RunBins      = 12;
   localparam int SignalBins   = 1024;
   localparam int MaxBases     = 1024;

   localparam int CountBits     = 16;
   localparam int CodeBits      = 3;
   localparam int FlowCountBits = 9;
   localparam int OpBits        = 2;
   localparam int StatusBits    = 3;

   localparam int FlowBits     = $clog2(Flows);
   localparam int FlowIdxBits  = $clog2(Flows + 1);
   localparam int RunBits      = $clog2(RunBins);
   localparam int SignalBits   = $clog2(SignalBins);
   localparam int BaseAddrBits = $clog2(MaxBases);
   localparam int BasePtrBits  = $clog2(MaxBases + 1);
   localparam int HistDepth    = Flows * RunBins * SignalBins;
   localparam int HistAddrBits = $clog2(HistDepth);

   // register file
   localparam int CsrAddrBits = 3;
   localparam int CsrDataBits = 32;
   localparam logic REG_FLOW_COUNT = 1'b0;
   localparam logic [FlowCountBits-1:0] FlowCountReset = FlowCountBits'(256);

   typedef enum logic [OpBits-1:0] {
      OP_LOAD  = 2'd0,
      OP_FLOW  = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [StatusBits-1:0] {
      STAT_OK   = 3'd0,
      STAT_FULL = 3'd1,
      STAT_FLOW = 3'd2,
      STAT_RUN  = 3'd3,
      STAT_SIG  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      SM_CLEAR,
      SM_IDLE,
      SM_SCAN,
      SM_QUERY,
      SM_INCR
   } state_type;

   typedef struct packed {
      logic                load;
      logic                start;
      logic [CodeBits-1:0] code;
      logic                scan_clear;
      logic                scan_en;
      logic [CodeBits-1:0] flow_base;
   } base_ctl_type;

   typedef struct packed {
      logic               full;
      logic               match;
      logic [RunBits-1:0] run;
      logic               run_clamp;
   } base_sts_type;

   typedef struct packed {
      logic                    rd;
      logic                    wr;
      logic [HistAddrBits-1:0] addr;
      logic [CountBits-1:0]    wdata;
   } hist_req_type;

   function automatic logic [HistAddrBits-1:0] hist_addr(
      input logic [FlowBits-1:0]   f,
      input logic [RunBits-1:0]    r,
      input logic [SignalBits-1:0] s
   );
      logic [HistAddrBits-1:0] row;
      row = HistAddrBits'(f) * HistAddrBits'(RunBins) + HistAddrBits'(r);
      return row * HistAddrBits'(SignalBins) + HistAddrBits'(s);
   endfunction

endpackage

[hdl/flow_signal_homopolymer_histogram.sv]
// channel   direction  ports                                       transfer
// request   in         start, busy, req_*                          start & !busy
// result    out        rsp_valid, rsp_count, rsp_run_length,       rsp_valid, one cycle
//                      rsp_status
// config    in/out     psel, penable, pwrite, paddr, pwdata,       psel & penable & pwrite
//                      prdata, pready
//
// a load, an unused operation or a rejected flow or query answers in the cycle after acceptance
// a query does one histogram read, then gives the result
// a flow of run n does one base store read per matched base plus the
// mismatch check, then a histogram read and write back
// after reset the histogram is zeroed one entry a cycle, with busy high
// the receiver cannot stall; results leave through an output register
module flow_signal_homopolymer_histogram (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [fshh_pkg::OpBits-1:0]          req_operation,
   input  logic                                 req_start_read,
   input  logic [2:0]                           req_base_code,
   input  logic [2:0]                           req_flow_base,
   input  logic [15:0]                          req_flow_signal,
   input  logic [7:0]                           req_query_flow,
   input  logic [3:0]                           req_query_run,
   input  logic [9:0]                           req_query_signal,
   output logic                                 rsp_valid,
   output logic [15:0]                          rsp_count,
   output logic [3:0]                           rsp_run_length,
   output logic [2:0]                           rsp_status,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [fshh_pkg::CsrAddrBits-1:0]     paddr,
   input  logic [fshh_pkg::CsrDataBits-1:0]     pwdata,
   output logic [fshh_pkg::CsrDataBits-1:0]     prdata,
   output logic                                 pready
);

   fshh_pkg::state_type state_ff, state_in;
   fshh_pkg::base_ctl_type base_ctl;
   fshh_pkg::base_sts_type base_sts;
   fshh_pkg::hist_req_type hist_req;
   fshh_pkg::op_type       op;
   fshh_pkg::status_type   status_in;

   logic [fshh_pkg::CountBits-1:0]     hist_rd_data;
   logic                               hist_ready;
   logic [fshh_pkg::FlowCountBits-1:0] flow_count_ff, flow_count_in;
   logic [fshh_pkg::FlowIdxBits-1:0]   flow_index_ff, flow_index_in;
   logic [fshh_pkg::CodeBits-1:0]      flow_base_ff, flow_base_in;
   logic [fshh_pkg::SignalBits-1:0]    sig_ff, sig_in;
   logic                               sig_clamp_ff, sig_clamp_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [fshh_pkg::CountBits-1:0]     rsp_count_ff, rsp_count_in;
   logic [fshh_pkg::RunBits-1:0]       rsp_run_ff, rsp_run_in;
   logic [fshh_pkg::StatusBits-1:0]    rsp_status_ff;
   logic                               accept;
   logic                               flow_over;
   logic                               csr_write;
   logic [fshh_pkg::CountBits-1:0]     count_inc;

   fshh_base_scan u_base_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (base_ctl),
      .sts   (base_sts)
   );

   fshh_hist_store u_hist_store (
      .clock   (clock),
      .reset   (reset),
      .req     (hist_req),
      .rd_data (hist_rd_data),
      .ready   (hist_ready)
   );

   assign busy      = (state_ff != fshh_pkg::SM_IDLE);
   assign accept    = start && !busy;
   assign op        = fshh_pkg::op_type'(req_operation);
   assign flow_over = (flow_index_ff >= fshh_pkg::FlowIdxBits'(flow_count_ff))
                      || (32'(flow_index_ff) >= fshh_pkg::Flows);
   assign count_inc = hist_rd_data + 1'b1;

   // register file
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   always_comb begin
      flow_count_in = flow_count_ff;
      if (csr_write && (paddr[2] == fshh_pkg::REG_FLOW_COUNT)) begin
         flow_count_in = pwdata[fshh_pkg::FlowCountBits-1:0];
      end
      prdata = '0;
      if (paddr[2] == fshh_pkg::REG_FLOW_COUNT) begin
         prdata = fshh_pkg::CsrDataBits'(flow_count_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fshh_pkg::SM_CLEAR: begin
            if (hist_ready) begin
               state_in = fshh_pkg::SM_IDLE;
            end
         end
         fshh_pkg::SM_IDLE: begin
            if (accept) begin
               case (op)
                  fshh_pkg::OP_FLOW: begin
                     if (!flow_over) begin
                        state_in = fshh_pkg::SM_SCAN;
                     end
                  end
                  fshh_pkg::OP_QUERY: begin
                     if ((32'(req_query_flow) < fshh_pkg::Flows)
                         && (32'(req_query_run) < fshh_pkg::RunBins)
                         && (32'(req_query_signal) < fshh_pkg::SignalBins)) begin
                        state_in = fshh_pkg::SM_QUERY;
                     end
                  end
                  default: state_in = fshh_pkg::SM_IDLE;
               endcase
            end
         end
         fshh_pkg::SM_SCAN: begin
            if (!base_sts.match) begin
               state_in = fshh_pkg::SM_INCR;
            end
         end
         fshh_pkg::SM_QUERY: state_in = fshh_pkg::SM_IDLE;
         fshh_pkg::SM_INCR:  state_in = fshh_pkg::SM_IDLE;
         default:            state_in = fshh_pkg::SM_CLEAR;
      endcase
   end

   // outputs and datapath
   always_comb begin
      base_ctl            = '0;
      base_ctl.flow_base  = flow_base_ff;
      base_ctl.code       = req_base_code;
      base_ctl.start      = req_start_read;
      hist_req            = '0;
      hist_req.addr       = fshh_pkg::hist_addr(flow_index_ff[fshh_pkg::FlowBits-1:0],
                                                base_sts.run, sig_ff);
      hist_req.wdata      = count_inc;
      flow_index_in       = flow_index_ff;
      flow_base_in        = flow_base_ff;
      sig_in              = sig_ff;
      sig_clamp_in        = sig_clamp_ff;
      rsp_valid_in        = 1'b0;
      rsp_count_in        = '0;
      rsp_run_in          = '0;
      status_in           = fshh_pkg::STAT_OK;

      case (state_ff)
         fshh_pkg::SM_IDLE: begin
            if (accept) begin
               case (op)
                  fshh_pkg::OP_LOAD: begin
                     base_ctl.load = 1'b1;
                     rsp_valid_in  = 1'b1;
                     if (req_start_read) begin
                        flow_index_in = '0;
                     end else if (base_sts.full) begin
                        status_in = fshh_pkg::STAT_FULL;
                     end
                  end
                  fshh_pkg::OP_FLOW: begin
                     if (flow_over) begin
                        rsp_valid_in = 1'b1;
                        status_in    = fshh_pkg::STAT_FLOW;
                     end else begin
                        base_ctl.scan_clear = 1'b1;
                        flow_base_in        = req_flow_base;
                        sig_clamp_in        = (32'(req_flow_signal) >= fshh_pkg::SignalBins);
                        sig_in              = sig_clamp_in
                                              ? fshh_pkg::SignalBits'(fshh_pkg::SignalBins - 1)
                                              : req_flow_signal[fshh_pkg::SignalBits-1:0];
                     end
                  end
                  fshh_pkg::OP_QUERY: begin
                     if (32'(req_query_flow) >= fshh_pkg::Flows) begin
                        rsp_valid_in = 1'b1;
                        status_in    = fshh_pkg::STAT_FLOW;
                     end else if (32'(req_query_run) >= fshh_pkg::RunBins) begin
                        rsp_valid_in = 1'b1;
                        status_in    = fshh_pkg::STAT_RUN;
                     end else if (32'(req_query_signal) >= fshh_pkg::SignalBins) begin
                        rsp_valid_in = 1'b1;
                        status_in    = fshh_pkg::STAT_SIG;
                     end else begin
                        hist_req.rd   = 1'b1;
                        hist_req.addr = fshh_pkg::hist_addr(
                           fshh_pkg::FlowBits'(req_query_flow),
                           fshh_pkg::RunBits'(req_query_run),
                           fshh_pkg::SignalBits'(req_query_signal));
                     end
                  end
                  fshh_pkg::OP_NONE: rsp_valid_in = 1'b1;
                  default:           rsp_valid_in = 1'b1;
               endcase
            end
         end
         fshh_pkg::SM_SCAN: begin
            base_ctl.scan_en = 1'b1;
            // run ends on the first mismatch: fetch its histogram count
            if (!base_sts.match) begin
               hist_req.rd = 1'b1;
            end
         end
         fshh_pkg::SM_QUERY: begin
            rsp_valid_in = 1'b1;
            rsp_count_in = hist_rd_data;
         end
         fshh_pkg::SM_INCR: begin
            hist_req.wr   = 1'b1;
            flow_index_in = flow_index_ff + 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_count_in  = count_inc;
            rsp_run_in    = base_sts.run;
            if (base_sts.run_clamp) begin
               status_in = fshh_pkg::STAT_RUN;
            end else if (sig_clamp_ff) begin
               status_in = fshh_pkg::STAT_SIG;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      flow_base_ff  <= flow_base_in;
      sig_ff        <= sig_in;
      sig_clamp_ff  <= sig_clamp_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fshh_pkg::SM_CLEAR;
         flow_index_ff <= '0;
         flow_count_ff <= fshh_pkg::FlowCountReset;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flow_index_ff <= flow_index_in;
         flow_count_ff <= flow_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_run_length = rsp_run_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

[hdl/fshh_base_scan.sv]
module fshh_base_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  fshh_pkg::base_ctl_type ctl,
   output fshh_pkg::base_sts_type sts
);

   logic [fshh_pkg::CodeBits-1:0]    mem [0:fshh_pkg::MaxBases-1];
   logic [fshh_pkg::CodeBits-1:0]    rd_data_ff;
   logic [fshh_pkg::BasePtrBits-1:0] loaded_ff, loaded_in, loaded_base;
   logic [fshh_pkg::BasePtrBits-1:0] ptr_ff, ptr_in;
   logic [fshh_pkg::RunBits-1:0]     run_ff, run_in;
   logic                             clamp_ff, clamp_in;
   logic                             do_write;
   logic                             match;
   logic [fshh_pkg::BaseAddrBits-1:0] waddr, raddr;

   always_comb begin
      loaded_base = (ctl.load && ctl.start) ? '0 : loaded_ff;
      do_write    = ctl.load && (32'(loaded_base) < fshh_pkg::MaxBases);
      loaded_in   = do_write ? loaded_base + 1'b1 : loaded_base;
      waddr       = loaded_base[fshh_pkg::BaseAddrBits-1:0];

      // rd_data_ff always holds the entry under the pointer
      match = ctl.scan_en && (ptr_ff < loaded_ff) && (rd_data_ff == ctl.flow_base);

      if (ctl.load && ctl.start) begin
         ptr_in = '0;
      end else if (match) begin
         ptr_in = ptr_ff + 1'b1;
      end else begin
         ptr_in = ptr_ff;
      end
      raddr = ptr_in[fshh_pkg::BaseAddrBits-1:0];

      run_in   = run_ff;
      clamp_in = clamp_ff;
      if (ctl.scan_clear) begin
         run_in   = '0;
         clamp_in = 1'b0;
      end else if (match) begin
         if (32'(run_ff) == fshh_pkg::RunBins - 1) begin
            clamp_in = 1'b1;
         end else begin
            run_in = run_ff + 1'b1;
         end
      end

      sts.full      = (32'(loaded_ff) == fshh_pkg::MaxBases);
      sts.match     = match;
      sts.run       = run_ff;
      sts.run_clamp = clamp_ff;
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[waddr] <= ctl.code;
      end
      // forward a base written under the pointer
      if (do_write && (waddr == raddr)) begin
         rd_data_ff <= ctl.code;
      end else begin
         rd_data_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         ptr_ff    <= '0;
         run_ff    <= '0;
         clamp_ff  <= 1'b0;
      end else begin
         loaded_ff <= loaded_in;
         ptr_ff    <= ptr_in;
         run_ff    <= run_in;
         clamp_ff  <= clamp_in;
      end
   end

endmodule

[hdl/fshh_hist_store.sv]
module fshh_hist_store (
   input  logic                           clock,
   input  logic                           reset,
   input  fshh_pkg::hist_req_type         req,
   output logic [fshh_pkg::CountBits-1:0] rd_data,
   output logic                           ready
);

   logic [fshh_pkg::CountBits-1:0]    mem [0:fshh_pkg::HistDepth-1];
   logic [fshh_pkg::CountBits-1:0]    rd_data_ff;
   logic [fshh_pkg::HistAddrBits-1:0] clear_addr_ff, clear_addr_in;
   logic                              clearing_ff, clearing_in;
   logic                              last;

   always_comb begin
      last          = (32'(clear_addr_ff) == fshh_pkg::HistDepth - 1);
      clear_addr_in = clearing_ff ? clear_addr_ff + 1'b1 : clear_addr_ff;
      clearing_in   = clearing_ff && !last;
   end

   // zeroing sweep after reset, then normal read and write traffic
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clear_addr_ff] <= '0;
      end else if (req.wr) begin
         mem[req.addr] <= req.wdata;
      end
      if (req.rd) begin
         rd_data_ff <= mem[req.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clearing_ff;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int          IdleLimit   = 3 * fshh_pkg::HistDepth;
   localparam int          DrainCycles = 32;
   localparam int          MaxPrinted  = 100;
   localparam int          RecentCells = 64;

   typedef struct {
      fshh_pkg::op_type                 operation;
      logic                             start_read;
      logic [fshh_pkg::CodeBits-1:0]    base_code;
      logic [fshh_pkg::CodeBits-1:0]    flow_base;
      logic [15:0]                      flow_signal;
      logic [7:0]                       query_flow;
      logic [3:0]                       query_run;
      logic [9:0]                       query_signal;
   } tally_req_type;

   typedef struct {
      logic [fshh_pkg::CountBits-1:0]   count;
      logic [3:0]                       run_length;
      fshh_pkg::status_type             status;
   } tally_rsp_type;

   // predicts the histogram and the base walk, holds the answers still to come
   class homopolymer_tally;
      logic [fshh_pkg::FlowCountBits-1:0] flow_count;
      logic [fshh_pkg::CodeBits-1:0]      bases [fshh_pkg::MaxBases];
      int unsigned                        loaded;
      int unsigned                        pointer;
      int unsigned                        flow_idx;
      logic [fshh_pkg::CountBits-1:0]     counts [int unsigned];
      tally_rsp_type                      awaited [$];
      int unsigned                        recent_cells [$];
      int unsigned                        n_op [4];
      int unsigned                        n_status [5];
      int unsigned                        n_wraps;

      function new();
         flow_count = fshh_pkg::FlowCountReset;
         loaded     = 0;
         pointer    = 0;
         flow_idx   = 0;
         n_wraps    = 0;
      endfunction

      function int unsigned cell_key(int unsigned f, int unsigned r, int unsigned s);
         return (f * fshh_pkg::RunBins + r) * fshh_pkg::SignalBins + s;
      endfunction

      function void note_request(tally_req_type rq);
         tally_rsp_type rs;
         int unsigned limit;
         int unsigned run;
         int unsigned sig;
         int unsigned key;
         int unsigned qf;
         int unsigned qr;
         int unsigned qs;
         rs.count      = '0;
         rs.run_length = '0;
         rs.status     = fshh_pkg::STAT_OK;
         n_op[int'(rq.operation)]++;
         case (rq.operation)
            fshh_pkg::OP_LOAD: begin
               if (rq.start_read) begin
                  loaded   = 0;
                  pointer  = 0;
                  flow_idx = 0;
               end
               if (loaded >= fshh_pkg::MaxBases) begin
                  rs.status = fshh_pkg::STAT_FULL;
               end else begin
                  bases[loaded] = rq.base_code;
                  loaded++;
               end
            end
            fshh_pkg::OP_FLOW: begin
               limit = (flow_count < fshh_pkg::Flows) ? flow_count : fshh_pkg::Flows;
               if (flow_idx >= limit) begin
                  rs.status = fshh_pkg::STAT_FLOW;
               end else begin
                  run = 0;
                  while (pointer < loaded && bases[pointer] == rq.flow_base) begin
                     run++;
                     pointer++;
                  end
                  sig = rq.flow_signal;
                  if (run >= fshh_pkg::RunBins) begin
                     run       = fshh_pkg::RunBins - 1;
                     rs.status = fshh_pkg::STAT_RUN;
                  end
                  if (sig >= fshh_pkg::SignalBins) begin
                     sig = fshh_pkg::SignalBins - 1;
                     if (rs.status == fshh_pkg::STAT_OK) rs.status = fshh_pkg::STAT_SIG;
                  end
                  key = cell_key(flow_idx, run, sig);
                  if (!counts.exists(key)) counts[key] = '0;
                  counts[key] = counts[key] + 1'b1;
                  if (counts[key] == '0) n_wraps++;
                  flow_idx++;
                  rs.count      = counts[key];
                  rs.run_length = 4'(run);
                  recent_cells.push_back(key);
                  if (recent_cells.size() > RecentCells) void'(recent_cells.pop_front());
               end
            end
            fshh_pkg::OP_QUERY: begin
               qf = rq.query_flow;
               qr = rq.query_run;
               qs = rq.query_signal;
               if (qf >= fshh_pkg::Flows) rs.status = fshh_pkg::STAT_FLOW;
               else if (qr >= fshh_pkg::RunBins) rs.status = fshh_pkg::STAT_RUN;
               else if (qs >= fshh_pkg::SignalBins) rs.status = fshh_pkg::STAT_SIG;
               else begin
                  key = cell_key(qf, qr, qs);
                  if (counts.exists(key)) rs.count = counts[key];
               end
            end
            default: ;
         endcase
         n_status[int'(rs.status)]++;
         awaited.push_back(rs);
      endfunction

      function bit check_response(tally_rsp_type got, output string why);
         tally_rsp_type want;
         why = "";
         if (awaited.size() == 0) begin
            why = " result with no transaction outstanding";
            return 1'b1;
         end
         want = awaited.pop_front();
         if (got.count !== want.count)
            why = {why, $sformatf(" count %0d want %0d", got.count, want.count)};
         if (got.run_length !== want.run_length)
            why = {why, $sformatf(" run_length %0d want %0d", got.run_length,
                                  want.run_length)};
         if (got.status !== want.status)
            why = {why, $sformatf(" status %0d want %0d", got.status, want.status)};
         return why != "";
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic [fshh_pkg::OpBits-1:0]        req_operation    = '0;
   logic                               req_start_read   = 1'b0;
   logic [2:0]                         req_base_code    = '0;
   logic [2:0]                         req_flow_base    = '0;
   logic [15:0]                        req_flow_signal  = '0;
   logic [7:0]                         req_query_flow   = '0;
   logic [3:0]                         req_query_run    = '0;
   logic [9:0]                         req_query_signal = '0;
   logic                               rsp_valid;
   logic [15:0]                        rsp_count;
   logic [3:0]                         rsp_run_length;
   logic [2:0]                         rsp_status;
   logic                               psel    = 1'b0;
   logic                               penable = 1'b0;
   logic                               pwrite  = 1'b0;
   logic [fshh_pkg::CsrAddrBits-1:0]   paddr   = '0;
   logic [fshh_pkg::CsrDataBits-1:0]   pwdata  = '0;
   logic [fshh_pkg::CsrDataBits-1:0]   prdata;
   logic                               pready;

   homopolymer_tally tally = new();
   int unsigned      idle_pct   = 0;
   int unsigned      issued     = 0;
   int unsigned      checked    = 0;
   int unsigned      mismatches = 0;
   int unsigned      stalled    = 0;
   logic [fshh_pkg::CodeBits-1:0] run_code = '0;
   int unsigned      run_left   = 0;
   tally_rsp_type    seen_rsp;
   string            why;

   flow_signal_homopolymer_histogram u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_start_read   (req_start_read),
      .req_base_code    (req_base_code),
      .req_flow_base    (req_flow_base),
      .req_flow_signal  (req_flow_signal),
      .req_query_flow   (req_query_flow),
      .req_query_run    (req_query_run),
      .req_query_signal (req_query_signal),
      .rsp_valid        (rsp_valid),
      .rsp_count        (rsp_count),
      .rsp_run_length   (rsp_run_length),
      .rsp_status       (rsp_status),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MaxPrinted)
         $display("[%0t] mismatch on result %0d:%s", $time, checked, msg);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         seen_rsp.count      = rsp_count;
         seen_rsp.run_length = rsp_run_length;
         seen_rsp.status     = fshh_pkg::status_type'(rsp_status);
         if (tally.check_response(seen_rsp, why)) report_mismatch(why);
         checked++;
      end
   end

   // the clearing pass after reset is the longest quiet stretch
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (psel && penable && pwrite && pready))
         stalled = 0;
      else
         stalled++;
      if (stalled >= IdleLimit) begin
         $display("watchdog: no transaction for %0d cycles", stalled);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic tally_req_type random_request();
      tally_req_type rq;
      rq.operation    = fshh_pkg::op_type'($urandom_range(3));
      rq.start_read   = 1'($urandom);
      rq.base_code    = fshh_pkg::CodeBits'($urandom);
      rq.flow_base    = fshh_pkg::CodeBits'($urandom);
      rq.flow_signal  = 16'($urandom);
      rq.query_flow   = 8'($urandom);
      rq.query_run    = 4'($urandom);
      rq.query_signal = 10'($urandom);
      return rq;
   endfunction

   function automatic tally_req_type load_req(logic first,
                                              logic [fshh_pkg::CodeBits-1:0] code);
      tally_req_type rq;
      rq            = random_request();
      rq.operation  = fshh_pkg::OP_LOAD;
      rq.start_read = first;
      rq.base_code  = code;
      return rq;
   endfunction

   function automatic tally_req_type flow_req(logic [fshh_pkg::CodeBits-1:0] code,
                                              logic [15:0] sig);
      tally_req_type rq;
      rq             = random_request();
      rq.operation   = fshh_pkg::OP_FLOW;
      rq.flow_base   = code;
      rq.flow_signal = sig;
      return rq;
   endfunction

   function automatic tally_req_type query_req(int unsigned f, int unsigned r,
                                               int unsigned s);
      tally_req_type rq;
      rq              = random_request();
      rq.operation    = fshh_pkg::OP_QUERY;
      rq.query_flow   = 8'(f);
      rq.query_run    = 4'(r);
      rq.query_signal = 10'(s);
      return rq;
   endfunction

   // homopolymer runs: each run differs from the one before, a few are long
   function automatic logic [fshh_pkg::CodeBits-1:0] next_code();
      if (run_left == 0) begin
         run_code = run_code + fshh_pkg::CodeBits'($urandom_range(1, 7));
         run_left = ($urandom_range(19) == 0)
                    ? $urandom_range(fshh_pkg::RunBins, fshh_pkg::RunBins + 4)
                    : $urandom_range(1, 3);
      end
      run_left--;
      return run_code;
   endfunction

   function automatic logic [15:0] pick_signal();
      case ($urandom_range(9))
         0:       return 16'($urandom_range(fshh_pkg::SignalBins, 16'hFFFF));
         1: begin
            case ($urandom_range(3))
               0:       return 16'd0;
               1:       return 16'(fshh_pkg::SignalBins - 1);
               2:       return 16'(fshh_pkg::SignalBins);
               default: return 16'hFFFF;
            endcase
         end
         default: return 16'($urandom_range(fshh_pkg::SignalBins - 1));
      endcase
   endfunction

   // mostly follows the stored read so that runs get consumed
   function automatic tally_req_type next_flow();
      tally_req_type rq;
      rq = flow_req(fshh_pkg::CodeBits'($urandom), pick_signal());
      if (tally.pointer < tally.loaded && $urandom_range(9) < 8)
         rq.flow_base = tally.bases[tally.pointer];
      return rq;
   endfunction

   function automatic tally_req_type next_query();
      int unsigned key;
      if (tally.recent_cells.size() != 0 && $urandom_range(9) < 7) begin
         key = tally.recent_cells[$urandom_range(tally.recent_cells.size() - 1)];
         return query_req(key / (fshh_pkg::SignalBins * fshh_pkg::RunBins),
                          (key / fshh_pkg::SignalBins) % fshh_pkg::RunBins,
                          key % fshh_pkg::SignalBins);
      end
      return query_req($urandom_range(fshh_pkg::Flows - 1), $urandom_range(15),
                       $urandom_range(fshh_pkg::SignalBins - 1));
   endfunction

   task automatic drive_request(tally_req_type rq);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start            <= 1'b1;
      req_operation    <= rq.operation;
      req_start_read   <= rq.start_read;
      req_base_code    <= rq.base_code;
      req_flow_base    <= rq.flow_base;
      req_flow_signal  <= rq.flow_signal;
      req_query_flow   <= rq.query_flow;
      req_query_run    <= rq.query_run;
      req_query_signal <= rq.query_signal;
      do @(posedge clock); while (busy);
      tally.note_request(rq);
      if (rq.operation != fshh_pkg::OP_NONE) issued++;
   endtask

   task automatic write_flow_count(int unsigned value);
      start <= 1'b0;
      while (tally.awaited.size() != 0 || busy) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= fshh_pkg::CsrAddrBits'(4 * int'(fshh_pkg::REG_FLOW_COUNT));
      pwdata  <= fshh_pkg::CsrDataBits'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tally.flow_count = fshh_pkg::FlowCountBits'(value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic run_read(int unsigned n_bases, int unsigned n_flows);
      drive_request(load_req(1'b1, next_code()));
      repeat (n_bases - 1) drive_request(load_req(1'b0, next_code()));
      repeat (n_flows) begin
         drive_request(next_flow());
         if ($urandom_range(4) == 0) drive_request(next_query());
      end
   endtask

   task automatic run_mix(int unsigned n_items);
      int unsigned stop_at;
      int unsigned n_bases;
      stop_at = issued + n_items;
      while (issued < stop_at) begin
         if ($urandom_range(4) == 0) begin
            drive_request(random_request());
         end else begin
            n_bases = $urandom_range(1, 24);
            run_read(n_bases, n_bases / 2 + $urandom_range(6));
         end
      end
   endtask

   initial begin
      tally_req_type rq;
      idle_pct = 35;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // fresh histogram, bad run bin, flow with no bases loaded
      drive_request(query_req(0, 0, 0));
      drive_request(query_req(fshh_pkg::Flows - 1, fshh_pkg::RunBins - 1,
                              fshh_pkg::SignalBins - 1));
      drive_request(query_req(fshh_pkg::Flows - 1, 15, fshh_pkg::SignalBins - 1));
      drive_request(flow_req(3'd0, 16'd0));
      rq = random_request();
      rq.operation  = fshh_pkg::OP_NONE;
      rq.start_read = 1'b1;
      drive_request(rq);
      // long run that clamps together with a clamped signal
      drive_request(load_req(1'b1, 3'd7));
      repeat (fshh_pkg::RunBins) drive_request(load_req(1'b0, 3'd7));
      drive_request(load_req(1'b0, 3'd0));
      drive_request(flow_req(3'd7, 16'hFFFF));
      drive_request(flow_req(3'd0, 16'(fshh_pkg::SignalBins)));
      drive_request(flow_req(3'd5, 16'(fshh_pkg::SignalBins - 1)));
      rq = flow_req(3'd5, 16'd0);
      rq.start_read = 1'b1;
      drive_request(rq);
      drive_request(query_req(0, fshh_pkg::RunBins - 1, fshh_pkg::SignalBins - 1));
      drive_request(query_req(1, 1, fshh_pkg::SignalBins - 1));

      write_flow_count(1);
      run_mix(150);
      write_flow_count($urandom_range(2, fshh_pkg::Flows - 1));
      run_mix(250);

      idle_pct = 62;
      write_flow_count(fshh_pkg::Flows);
      run_mix(200);

      idle_pct = 0;
      write_flow_count($urandom_range(2, fshh_pkg::Flows - 1));
      run_mix(200);

      start <= 1'b0;
      while (tally.awaited.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("ran %0d loads, %0d flows, %0d queries, %0d unused ops; %0d results checked",
               tally.n_op[fshh_pkg::OP_LOAD], tally.n_op[fshh_pkg::OP_FLOW],
               tally.n_op[fshh_pkg::OP_QUERY], tally.n_op[fshh_pkg::OP_NONE], checked);
      $display("seen: %0d store full, %0d flow over limit, %0d run clamp, %0d signal clamp",
               tally.n_status[fshh_pkg::STAT_FULL], tally.n_status[fshh_pkg::STAT_FLOW],
               tally.n_status[fshh_pkg::STAT_RUN], tally.n_status[fshh_pkg::STAT_SIG]);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[sim.f]
hdl/fshh_pkg.sv
hdl/fshh_base_scan.sv
hdl/fshh_hist_store.sv
hdl/flow_signal_homopolymer_histogram.sv
verif/tb_top.sv
